>>> rtl/cqfs_pkg.sv
`timescale 1ns / 1ps
package cqfs_pkg;

  localparam int DEPTH      = 16;
  localparam int ENTRY_BITS = 24;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int OFF_W      = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ        = 3'd0,
    OP_DEQ        = 3'd1,
    OP_PEEK_FRONT = 3'd2,
    OP_PEEK_REAR  = 3'd3,
    OP_SWAP       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C
  } state_t;

  typedef struct packed {
    logic [ENTRY_BITS-1:0] data;
    status_t               status;
    logic [CNT_W-1:0]      count;
    logic                  full;
    logic                  empty;
  } res_t;

endpackage

>>> rtl/cqfs_ram.sv
`timescale 1ns / 1ps
module cqfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cqfs_ctrl.sv
`timescale 1ns / 1ps
module cqfs_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cqfs_pkg::OP_W-1:0]           op_in,
  input  logic [cqfs_pkg::ENTRY_BITS-1:0]     value_in,
  input  logic [cqfs_pkg::OFF_W-1:0]          offset_in,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cqfs_pkg::CNT_W-1:0]          cfg_data,
  input  logic                                out_free,
  output logic                                res_vld,
  output cqfs_pkg::res_t                      res_o,
  output logic                                mem_en,
  output logic                                mem_we,
  output logic [cqfs_pkg::IDX_W-1:0]          mem_addr,
  output logic [cqfs_pkg::ENTRY_BITS-1:0]     mem_wdata,
  input  logic [cqfs_pkg::ENTRY_BITS-1:0]     mem_rdata
);

  cqfs_pkg::state_t                  state_r, state_nxt;
  logic [cqfs_pkg::IDX_W-1:0]        head_r, head_nxt;
  logic [cqfs_pkg::IDX_W-1:0]        tail_r, tail_nxt;
  logic [cqfs_pkg::IDX_W-1:0]        other_r, other_nxt;
  logic [cqfs_pkg::CNT_W-1:0]        occ_r, occ_nxt;
  logic [cqfs_pkg::CNT_W-1:0]        cap_r, cap_nxt;
  logic [cqfs_pkg::ENTRY_BITS-1:0]   hold_r, hold_nxt;
  cqfs_pkg::res_t                    res_r, res_nxt;
  logic [cqfs_pkg::CNT_W-1:0]        sum;
  logic [cqfs_pkg::CNT_W-1:0]        cap_sat;

  function automatic logic [cqfs_pkg::IDX_W-1:0] nidx(
    input logic [cqfs_pkg::IDX_W-1:0] i,
    input logic [cqfs_pkg::CNT_W-1:0] cap
  );
    logic [cqfs_pkg::CNT_W-1:0] s;
    s = cqfs_pkg::CNT_W'(i) + cqfs_pkg::CNT_W'(1);
    return (s >= cap) ? '0 : s[cqfs_pkg::IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cqfs_pkg::S_IDLE;
      head_r  <= '0;
      tail_r  <= cqfs_pkg::IDX_W'(cqfs_pkg::DEPTH - 1);
      occ_r   <= '0;
      cap_r   <= cqfs_pkg::CNT_W'(cqfs_pkg::DEPTH);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    other_r <= other_nxt;
    hold_r  <= hold_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    cap_nxt   = cap_r;
    other_nxt = other_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    res_vld   = 1'b0;
    res_o     = res_r;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = head_r;
    mem_wdata = value_in;
    in_ready  = (state_r == cqfs_pkg::S_IDLE) && out_free;
    cfg_ready = (state_r == cqfs_pkg::S_IDLE);

    sum = cqfs_pkg::CNT_W'(head_r) + cqfs_pkg::CNT_W'(offset_in);
    if (sum >= cap_r) begin
      sum = sum - cap_r;
    end

    unique case (state_r)
      cqfs_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          res_nxt.data   = '0;
          res_nxt.status = cqfs_pkg::ST_OK;
          case (cqfs_pkg::op_t'(op_in))
            cqfs_pkg::OP_ENQ: begin
              if (occ_r >= cap_r) begin
                res_nxt.status = cqfs_pkg::ST_FULL;
              end else begin
                tail_nxt  = nidx(tail_r, cap_r);
                occ_nxt   = occ_r + cqfs_pkg::CNT_W'(1);
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = tail_nxt;
                mem_wdata = value_in;
              end
            end
            cqfs_pkg::OP_DEQ: begin
              if (occ_r == '0) begin
                res_nxt.status = cqfs_pkg::ST_EMPTY;
              end else begin
                mem_en    = 1'b1;
                mem_addr  = head_r;
                head_nxt  = nidx(head_r, cap_r);
                occ_nxt   = occ_r - cqfs_pkg::CNT_W'(1);
                state_nxt = cqfs_pkg::S_READ;
              end
            end
            cqfs_pkg::OP_PEEK_FRONT: begin
              if (occ_r == '0) begin
                res_nxt.status = cqfs_pkg::ST_EMPTY;
              end else begin
                mem_en    = 1'b1;
                mem_addr  = head_r;
                state_nxt = cqfs_pkg::S_READ;
              end
            end
            cqfs_pkg::OP_PEEK_REAR: begin
              if (occ_r == '0) begin
                res_nxt.status = cqfs_pkg::ST_EMPTY;
              end else begin
                mem_en    = 1'b1;
                mem_addr  = tail_r;
                state_nxt = cqfs_pkg::S_READ;
              end
            end
            cqfs_pkg::OP_SWAP: begin
              if (occ_r == '0) begin
                res_nxt.status = cqfs_pkg::ST_EMPTY;
              end else if (cqfs_pkg::CNT_W'(offset_in) >= occ_r) begin
                res_nxt.status = cqfs_pkg::ST_RANGE;
              end else if (offset_in != '0) begin
                mem_en    = 1'b1;
                mem_addr  = head_r;
                other_nxt = sum[cqfs_pkg::IDX_W-1:0];
                state_nxt = cqfs_pkg::S_SWAP_A;
              end
            end
            default: begin
            end
          endcase
          res_nxt.count = occ_nxt;
          res_nxt.full  = (occ_nxt == cap_r);
          res_nxt.empty = (occ_nxt == '0);
          if (state_nxt == cqfs_pkg::S_IDLE) begin
            res_vld = 1'b1;
            res_o   = res_nxt;
          end
        end
        if (cfg_valid) begin
          cap_sat = cfg_data;
          if (cap_sat == '0) begin
            cap_sat = cqfs_pkg::CNT_W'(1);
          end else if (cap_sat > cqfs_pkg::CNT_W'(cqfs_pkg::DEPTH)) begin
            cap_sat = cqfs_pkg::CNT_W'(cqfs_pkg::DEPTH);
          end
          cap_nxt  = cap_sat;
          head_nxt = '0;
          tail_nxt = cqfs_pkg::IDX_W'(cap_sat - cqfs_pkg::CNT_W'(1));
          occ_nxt  = '0;
        end else begin
          cap_sat = cap_r;
        end
      end
      cqfs_pkg::S_READ: begin
        cap_sat    = cap_r;
        res_vld    = 1'b1;
        res_o      = res_r;
        res_o.data = mem_rdata;
        state_nxt  = cqfs_pkg::S_IDLE;
      end
      cqfs_pkg::S_SWAP_A: begin
        cap_sat   = cap_r;
        hold_nxt  = mem_rdata;
        mem_en    = 1'b1;
        mem_addr  = other_r;
        state_nxt = cqfs_pkg::S_SWAP_B;
      end
      cqfs_pkg::S_SWAP_B: begin
        cap_sat   = cap_r;
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = head_r;
        mem_wdata = mem_rdata;
        state_nxt = cqfs_pkg::S_SWAP_C;
      end
      cqfs_pkg::S_SWAP_C: begin
        cap_sat   = cap_r;
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = other_r;
        mem_wdata = hold_r;
        res_vld   = 1'b1;
        res_o     = res_r;
        state_nxt = cqfs_pkg::S_IDLE;
      end
      default: begin
        cap_sat   = cap_r;
        state_nxt = cqfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/circular_queue_with_front_swap.sv
`timescale 1ns / 1ps
// Ring-buffer queue of 24-bit entries with a programmable capacity of 1 to 16.
// Input channel in_*: one operation per transfer; in_tuser carries the
// operation code, in_tdata the value and the swap offset. Result channel
// out_*: exactly one result per operation, in order; out_tuser carries the
// status, out_tdata the data, count and full/empty flags.
// Configuration channel cfg_*: a transfer writes the capacity (0 reads as 1,
// above 16 reads as 16) and empties the queue; it is taken only between
// operations.
// Enqueue, rejected and no-op items give their result from the idle state;
// dequeue and peeks give it from S_READ after the entry read; a swap with
// nonzero offset runs through S_SWAP_A, S_SWAP_B and S_SWAP_C. One item is
// in work at a time. The single-port entry memory allows one read or one
// write per cycle, and a swap takes two reads and two writes.
// A result register sits on the output; while it holds an untaken result
// the next input transfer waits until out_tready takes it.
// Reset (rst_n low, synchronous) leaves the queue empty with capacity 16.
module circular_queue_with_front_swap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // item_value[23:0], swap_offset[27:24], zero pad
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_out[23:0], entry_count[28:24], is_full[29],
                                  // is_empty[30], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic                               out_valid_r;
  cqfs_pkg::res_t                     out_res_r;
  logic                               out_free;
  logic                               res_vld;
  cqfs_pkg::res_t                     res;
  logic                               mem_en;
  logic                               mem_we;
  logic [cqfs_pkg::IDX_W-1:0]         mem_addr;
  logic [cqfs_pkg::ENTRY_BITS-1:0]    mem_wdata;
  logic [cqfs_pkg::ENTRY_BITS-1:0]    mem_rdata;

  assign out_free = !out_valid_r || out_tready;

  cqfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op_in     (in_tuser),
    .value_in  (in_tdata[23:0]),
    .offset_in (in_tdata[27:24]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .res_vld   (res_vld),
    .res_o     (res),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  cqfs_ram #(
    .WIDTH (cqfs_pkg::ENTRY_BITS),
    .DEPTH (cqfs_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.empty, out_res_r.full, out_res_r.count,
                       out_res_r.data};
  assign out_tuser  = out_res_r.status;

endmodule
